// ===== rtl/segregated_bin_allocator_macros.svh =====
// Assertion macros for the segregated bin allocator.
`ifndef SEGREGATED_BIN_ALLOCATOR_MACROS_SVH
`define SEGREGATED_BIN_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that the consequent holds in the same cycle as the antecedent.
`define SBA_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("segregated_bin_allocator: same-cycle check failed");
// Check that the consequent holds in the cycle after the antecedent.
`define SBA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("segregated_bin_allocator: next-cycle check failed");
`else
`define SBA_ASSERT_SAME(label, clk, rstn, ante, cons)
`define SBA_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/sba_pkg.sv =====
// Shared constants, status codes and controller command type for the bin allocator.
`timescale 1ns / 1ps
package sba_pkg;

    localparam int BIN_NUMBER_DEF    = 10;
    localparam int HEAP_GRANULES_DEF = 4096;

    localparam int GRANULE_BYTES = 16;
    localparam int GRANULE_SHIFT = $clog2(GRANULE_BYTES);

    localparam int SIZE_W     = 16;
    localparam int ADDR_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int LIMIT_W    = 13;
    localparam int CNT_W      = SIZE_W - GRANULE_SHIFT + 1;
    localparam int FREE_PTR_W = ADDR_W - GRANULE_SHIFT;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_OOM     = 2'd2;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic apply;
        logic load_now;
        logic load_held;
    } sba_cmd_t;

endpackage

// ===== rtl/sba_ctrl.sv =====
// Controller state machine: request sequencing and result valid.
`timescale 1ns / 1ps
module sba_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output sba_pkg::sba_cmd_t cmd
);
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOOK  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    // Hold ready low while reset is applied so no request is taken and lost.
    assign s_ready  = aresetn && (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOOK;
                end
            end
            S_LOOK: begin
                cmd.lookup = 1'b1;
                state_next = S_APPLY;
            end
            S_APPLY: begin
                cmd.apply = 1'b1;
                if (out_free) begin
                    cmd.load_now = 1'b1;
                    state_next   = S_IDLE;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    cmd.load_held = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid_next = (m_valid_reg && !m_ready) || cmd.load_now || cmd.load_held;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/sba_datapath.sv =====
// Datapath: bin heads, heap top, link/size memory, lookup and update logic.
`timescale 1ns / 1ps
module sba_datapath #(
    parameter int BIN_NUMBER    = sba_pkg::BIN_NUMBER_DEF,
    parameter int HEAP_GRANULES = sba_pkg::HEAP_GRANULES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sba_pkg::sba_cmd_t             cmd,
    input  logic                          cfg_wr_en,
    input  logic [sba_pkg::LIMIT_W-1:0]   cfg_wr_data,
    input  logic                          s_opcode,
    input  logic [sba_pkg::SIZE_W-1:0]    s_request_size,
    input  logic [sba_pkg::ADDR_W-1:0]    s_block_address,
    output logic [sba_pkg::ADDR_W-1:0]    m_result_address,
    output logic [sba_pkg::STATUS_W-1:0]  m_status,
    output logic                          m_reused_block
);
    import sba_pkg::*;

    localparam int BIN_W  = $clog2(BIN_NUMBER);
    localparam int HIDX_W = $clog2(HEAP_GRANULES);
    localparam int PTR_W  = $clog2(HEAP_GRANULES + 1);
    localparam int MEM_W  = PTR_W + HIDX_W;
    localparam int CMP_W  = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
    localparam int FCMP_W = (PTR_W > FREE_PTR_W) ? PTR_W : FREE_PTR_W;
    localparam logic [BIN_W-1:0] TOP_BIN = BIN_W'(BIN_NUMBER - 1);

    // Persistent allocator state
    logic [LIMIT_W-1:0] limit_reg;
    logic [PTR_W-1:0]   heads_reg [BIN_NUMBER];
    logic [PTR_W-1:0]   top_reg;
    logic [PTR_W-1:0]   top_next;
    logic [MEM_W-1:0]   mem [HEAP_GRANULES];
    logic [MEM_W-1:0]   mem_rd_reg;

    // Captured request
    logic               op_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [ADDR_W-1:0]  addr_reg;

    // Lookup results
    logic [CNT_W-1:0]   n_reg;
    logic [BIN_W-1:0]   hit_reg;
    logic               hit_ok_reg;
    logic [PTR_W-1:0]   ptr_reg;
    logic               ign_reg;

    // Held result
    logic [ADDR_W-1:0]   res_addr_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                res_reused_reg;

    // Lookup-phase logic
    logic [SIZE_W:0]         round_sum;
    logic [CNT_W-1:0]        n_c;
    logic [BIN_W-1:0]        bin_c;
    logic [BIN_W-1:0]        hit_c;
    logic                    hit_ok_c;
    logic [FREE_PTR_W-1:0]   fp_c;
    logic                    fvalid_c;
    logic [PTR_W-1:0]        ptr_c;
    logic                    ign_c;
    logic [HIDX_W-1:0]       rd_addr;
    logic [BIN_W-1:0]        head_rd_idx;
    logic [PTR_W-1:0]        head_rd;

    // Apply-phase logic
    logic [PTR_W-1:0]    rd_link;
    logic [HIDX_W-1:0]   rd_size;
    logic [BIN_W-1:0]    free_bin_c;
    logic                short_top;
    logic                pop;
    logic [CMP_W-1:0]    limit_x;
    logic [CMP_W-1:0]    lim_x;
    logic [CMP_W-1:0]    top_x;
    logic [CMP_W-1:0]    need_x;
    logic                oom;
    logic [PTR_W-1:0]    top_p1;
    logic                head_we;
    logic [BIN_W-1:0]    head_wa;
    logic [PTR_W-1:0]    head_wd;
    logic                mem_we;
    logic [HIDX_W-1:0]   mem_wa;
    logic [MEM_W-1:0]    mem_wd;
    logic [ADDR_W-1:0]   res_addr_c;
    logic [STATUS_W-1:0] res_status_c;
    logic                res_reused_c;

    // Round the byte count up to granules and cap it to a bin index.
    assign round_sum = {1'b0, size_reg} + (SIZE_W + 1)'(GRANULE_BYTES - 1);
    assign n_c       = round_sum[SIZE_W:GRANULE_SHIFT];
    assign bin_c     = (n_c >= CNT_W'(BIN_NUMBER - 1)) ? TOP_BIN : n_c[BIN_W-1:0];

    // Lowest non-empty bin at or above the request's bin.
    always_comb begin
        hit_c    = '0;
        hit_ok_c = 1'b0;
        for (int i = BIN_NUMBER - 1; i >= 0; i--) begin
            if (heads_reg[i] != '0 && BIN_W'(i) >= bin_c) begin
                hit_c    = BIN_W'(i);
                hit_ok_c = 1'b1;
            end
        end
    end

    assign fp_c     = addr_reg[ADDR_W-1:GRANULE_SHIFT];
    assign fvalid_c = (fp_c != '0) && (FCMP_W'(fp_c) <= FCMP_W'(HEAP_GRANULES));

    assign head_rd_idx = cmd.lookup ? hit_c : free_bin_c;
    assign head_rd     = heads_reg[head_rd_idx];

    assign ptr_c   = (op_reg == OP_ALLOC) ? head_rd : PTR_W'(fp_c);
    assign ign_c   = (op_reg == OP_ALLOC) ? (size_reg == '0) : !fvalid_c;
    assign rd_addr = HIDX_W'(ptr_c - PTR_W'(1));

    // Apply phase
    assign rd_link    = mem_rd_reg[MEM_W-1:HIDX_W];
    assign rd_size    = mem_rd_reg[HIDX_W-1:0];
    assign free_bin_c = (rd_size >= HIDX_W'(BIN_NUMBER - 1)) ? TOP_BIN : rd_size[BIN_W-1:0];
    assign short_top  = (hit_reg == TOP_BIN) && (CMP_W'(rd_size) < CMP_W'(n_reg));
    assign pop        = hit_ok_reg && !short_top;

    assign limit_x = CMP_W'(limit_reg);
    assign lim_x   = (limit_x > CMP_W'(HEAP_GRANULES)) ? CMP_W'(HEAP_GRANULES) : limit_x;
    assign top_x   = CMP_W'(top_reg);
    assign need_x  = CMP_W'(n_reg) + CMP_W'(1);
    assign oom     = (top_x >= lim_x) || (need_x > lim_x - top_x);
    assign top_p1  = top_reg + PTR_W'(1);

    always_comb begin
        res_addr_c   = '0;
        res_status_c = STAT_DONE;
        res_reused_c = 1'b0;
        head_we      = 1'b0;
        head_wa      = hit_reg;
        head_wd      = rd_link;
        mem_we       = 1'b0;
        mem_wa       = HIDX_W'(ptr_reg - PTR_W'(1));
        mem_wd       = {head_rd, rd_size};
        top_next     = top_reg;
        if (ign_reg) begin
            res_status_c = STAT_IGNORED;
        end else if (op_reg == OP_ALLOC) begin
            if (pop) begin
                head_we      = 1'b1;
                res_addr_c   = ADDR_W'({ptr_reg, {GRANULE_SHIFT{1'b0}}});
                res_reused_c = 1'b1;
            end else if (oom) begin
                res_status_c = STAT_OOM;
            end else begin
                mem_we     = 1'b1;
                mem_wa     = HIDX_W'(top_reg);
                mem_wd     = {{PTR_W{1'b0}}, HIDX_W'(n_reg)};
                top_next   = top_reg + PTR_W'(need_x);
                res_addr_c = ADDR_W'({top_p1, {GRANULE_SHIFT{1'b0}}});
            end
        end else begin
            mem_we  = 1'b1;
            head_we = 1'b1;
            head_wa = free_bin_c;
            head_wd = ptr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
            top_reg   <= '0;
            for (int i = 0; i < BIN_NUMBER; i++) begin
                heads_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (cmd.apply) begin
                top_reg <= top_next;
                if (head_we) begin
                    heads_reg[head_wa] <= head_wd;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.apply && mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.lookup) begin
            mem_rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= s_opcode;
            size_reg <= s_request_size;
            addr_reg <= s_block_address;
        end
        if (cmd.lookup) begin
            n_reg      <= n_c;
            hit_reg    <= hit_c;
            hit_ok_reg <= hit_ok_c;
            ptr_reg    <= ptr_c;
            ign_reg    <= ign_c;
        end
        if (cmd.apply) begin
            res_addr_reg   <= res_addr_c;
            res_status_reg <= res_status_c;
            res_reused_reg <= res_reused_c;
        end
        if (cmd.load_now) begin
            m_result_address <= res_addr_c;
            m_status         <= res_status_c;
            m_reused_block   <= res_reused_c;
        end else if (cmd.load_held) begin
            m_result_address <= res_addr_reg;
            m_status         <= res_status_reg;
            m_reused_block   <= res_reused_reg;
        end
    end

endmodule

// ===== rtl/segregated_bin_allocator.sv =====
// Top level of the segregated bin allocator: controller, datapath and checks.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------------------
//  s_       | in        | s_valid / s_ready  | s_opcode, s_request_size, s_block_address
//  m_       | out       | m_valid / m_ready  | m_result_address, m_status, m_reused_block
//  cfg_     | in        | cfg_wr_en          | cfg_wr_data (heap_limit in granules)
//
// Each request passes through capture, bin lookup with the link/size memory
// read, then the update and writeback. The link/size memory read is registered
// between lookup and update, and one request is in flight at a time.
// Reset clears bin heads, heap top, and sets heap_limit to 4096; memory
// contents are left as they are. A stalled result sits in the output
// register; the next request is still taken, and only its own result waits.
`timescale 1ns / 1ps
`include "segregated_bin_allocator_macros.svh"
module segregated_bin_allocator #(
    parameter int BIN_NUMBER    = sba_pkg::BIN_NUMBER_DEF,
    parameter int HEAP_GRANULES = sba_pkg::HEAP_GRANULES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [sba_pkg::LIMIT_W-1:0]   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [sba_pkg::SIZE_W-1:0]    s_request_size,
    input  logic [sba_pkg::ADDR_W-1:0]    s_block_address,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sba_pkg::ADDR_W-1:0]    m_result_address,
    output logic [sba_pkg::STATUS_W-1:0]  m_status,
    output logic                          m_reused_block
);
    import sba_pkg::*;

    // Command bundle from the controller to the datapath
    sba_cmd_t cmd;

    // Sequence each request: capture, lookup, apply, then hand off the result.
    sba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Hold allocator state and compute each request's outcome.
    sba_datapath #(
        .BIN_NUMBER    (BIN_NUMBER),
        .HEAP_GRANULES (HEAP_GRANULES)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_opcode         (s_opcode),
        .s_request_size   (s_request_size),
        .s_block_address  (s_block_address),
        .m_result_address (m_result_address),
        .m_status         (m_status),
        .m_reused_block   (m_reused_block)
    );

    // An accepted request moves straight into lookup.
    `SBA_ASSERT_NEXT(a_accept_to_lookup, aclk, aresetn, s_valid && s_ready, cmd.lookup)
    // Lookup is always followed by exactly one apply cycle.
    `SBA_ASSERT_NEXT(a_lookup_to_apply, aclk, aresetn, cmd.lookup, cmd.apply)
    // A result with a free output slot shows up on the next cycle.
    `SBA_ASSERT_NEXT(a_apply_to_valid, aclk, aresetn, cmd.apply && (!m_valid || m_ready), m_valid)
    // No new request is taken while one is still being worked.
    `SBA_ASSERT_SAME(a_ready_when_idle, aclk, aresetn, s_ready, !cmd.apply && !cmd.load_held)

endmodule
